>>> src/svt_pkg.sv
`timescale 1ns / 1ps
// Shared definitions for the sorted value table: operation and status codes,
// datapath select codes and the controller/datapath command and status structs.
// No dependencies.

package svt_pkg;

   localparam int unsigned DEF_CAPACITY = 64;

   localparam int unsigned OP_W     = 2;
   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned COUNT_W  = 7;

   // operation codes; the fourth code is a no-op
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

   // read address sources
   localparam logic [1:0] RD_SEL_SCAN   = 2'd0;
   localparam logic [1:0] RD_SEL_ISHIFT = 2'd1;
   localparam logic [1:0] RD_SEL_DSHIFT = 2'd2;

   // write address / data sources
   localparam logic [1:0] WR_SEL_VALUE  = 2'd0;
   localparam logic [1:0] WR_SEL_ISHIFT = 2'd1;
   localparam logic [1:0] WR_SEL_DSHIFT = 2'd2;

   typedef struct packed {
      logic                load_req;
      logic                idx_inc;
      logic                k_init;
      logic                k_dec;
      logic                rd_en;
      logic [1:0]          rd_sel;
      logic                wr_en;
      logic [1:0]          wr_sel;
      logic                occ_inc;
      logic                occ_dec;
      logic                set_res;
      logic                res_found;
      logic [STATUS_W-1:0] res_status;
      logic                rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            at_end;
      logic            full;
      logic            less;
      logic            equal;
      logic            ins_done;
      logic            del_done;
   } stat_type;

endpackage

>>> src/svt_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the sorted value table: request and response.
// Depends on svt_pkg for field widths.

interface svt_req_if;
   logic                               valid;
   logic                               ready;
   logic [svt_pkg::OP_W-1:0]           op;
   logic signed [svt_pkg::VALUE_W-1:0] value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface

interface svt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          found;
   logic [svt_pkg::STATUS_W-1:0]  status;
   logic [svt_pkg::COUNT_W-1:0]   entry_count;

   modport source (output valid, output found, output status, output entry_count,
                   input ready);
   modport sink   (input valid, input found, input status, input entry_count,
                   output ready);
endinterface

>>> src/svt_ram.sv
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with registered read data.
// No dependencies.

module svt_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/svt_dpath.sv
`timescale 1ns / 1ps
// Datapath of the sorted value table: entry RAM, scan index, shift pointer,
// occupancy and result registers. Depends on svt_pkg and svt_ram.

module svt_dpath #(
   parameter int unsigned CAPACITY = svt_pkg::DEF_CAPACITY
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [svt_pkg::OP_W-1:0]           req_op,
   input  logic signed [svt_pkg::VALUE_W-1:0] req_value,
   input  svt_pkg::cmd_type                   cmd,
   output svt_pkg::stat_type                  stat,
   output logic                               rsp_found,
   output logic [svt_pkg::STATUS_W-1:0]       rsp_status,
   output logic [svt_pkg::COUNT_W-1:0]        rsp_entry_count
);

   localparam int unsigned ADDR_W = $clog2(CAPACITY);
   localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);

   logic [svt_pkg::OP_W-1:0]           op_ff;
   logic signed [svt_pkg::VALUE_W-1:0] value_ff;
   logic [CNT_W-1:0]                   idx_ff, idx_in;
   logic [CNT_W-1:0]                   k_ff, k_in;
   logic [CNT_W-1:0]                   occ_ff, occ_in;
   logic                               found_ff;
   logic [svt_pkg::STATUS_W-1:0]       status_ff;
   logic                               rsp_found_ff;
   logic [svt_pkg::STATUS_W-1:0]       rsp_status_ff;
   logic [svt_pkg::COUNT_W-1:0]        rsp_count_ff;

   logic [CNT_W-1:0]                   idx_p1;
   logic [CNT_W-1:0]                   k_m1;
   logic [31:0]                        occ_wide;
   logic [ADDR_W-1:0]                  rd_addr;
   logic [ADDR_W-1:0]                  wr_addr;
   logic [svt_pkg::VALUE_W-1:0]        wr_data;
   logic [svt_pkg::VALUE_W-1:0]        rd_data;

   assign idx_p1   = idx_ff + CNT_W'(1);
   assign k_m1     = k_ff - CNT_W'(1);
   assign occ_wide = 32'(occ_ff);

   always_comb begin
      unique case (cmd.rd_sel)
         svt_pkg::RD_SEL_ISHIFT: rd_addr = k_m1[ADDR_W-1:0];
         svt_pkg::RD_SEL_DSHIFT: rd_addr = idx_p1[ADDR_W-1:0];
         default:                rd_addr = idx_ff[ADDR_W-1:0];
      endcase
   end

   always_comb begin
      unique case (cmd.wr_sel)
         svt_pkg::WR_SEL_ISHIFT: begin
            wr_addr = k_ff[ADDR_W-1:0];
            wr_data = rd_data;
         end
         svt_pkg::WR_SEL_DSHIFT: begin
            wr_addr = idx_ff[ADDR_W-1:0];
            wr_data = rd_data;
         end
         default: begin
            wr_addr = idx_ff[ADDR_W-1:0];
            wr_data = value_ff;
         end
      endcase
   end

   svt_ram #(
      .WIDTH (svt_pkg::VALUE_W),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      idx_in = idx_ff;
      if (cmd.load_req) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_p1;
      end

      k_in = k_ff;
      if (cmd.k_init) begin
         k_in = occ_ff;
      end else if (cmd.k_dec) begin
         k_in = k_m1;
      end

      occ_in = occ_ff;
      if (cmd.occ_inc) begin
         occ_in = occ_ff + CNT_W'(1);
      end else if (cmd.occ_dec) begin
         occ_in = occ_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      k_ff   <= k_in;
      if (cmd.load_req) begin
         op_ff    <= req_op;
         value_ff <= req_value;
      end
      if (cmd.set_res) begin
         found_ff  <= cmd.res_found;
         status_ff <= cmd.res_status;
      end
      if (cmd.rsp_load) begin
         rsp_found_ff  <= found_ff;
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= occ_wide[svt_pkg::COUNT_W-1:0];
      end
   end

   assign stat.op       = op_ff;
   assign stat.at_end   = (idx_ff == occ_ff);
   assign stat.full     = (occ_ff == CNT_W'(CAPACITY));
   assign stat.less     = ($signed(rd_data) < value_ff);
   assign stat.equal    = ($signed(rd_data) == value_ff);
   assign stat.ins_done = (k_ff == idx_ff);
   assign stat.del_done = (idx_p1 == occ_ff);

   assign rsp_found       = rsp_found_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

>>> src/svt_ctrl.sv
`timescale 1ns / 1ps
// Controller of the sorted value table: sequences scan, shift and response
// for one request at a time. Depends on svt_pkg.

module svt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  svt_pkg::stat_type stat,
   output svt_pkg::cmd_type  cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DISPATCH = 4'd1;
   localparam logic [3:0] S_SCAN     = 4'd2;
   localparam logic [3:0] S_CMP      = 4'd3;
   localparam logic [3:0] S_ISH_RD   = 4'd4;
   localparam logic [3:0] S_ISH_WR   = 4'd5;
   localparam logic [3:0] S_DSH_RD   = 4'd6;
   localparam logic [3:0] S_DSH_WR   = 4'd7;
   localparam logic [3:0] S_FINISH   = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (stat.op)
               svt_pkg::OP_INSERT: begin
                  if (stat.full) begin
                     cmd.set_res    = 1'b1;
                     cmd.res_status = svt_pkg::ST_FULL;
                     state_in       = S_FINISH;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               svt_pkg::OP_LOOKUP, svt_pkg::OP_DELETE: state_in = S_SCAN;
               default: begin
                  cmd.set_res    = 1'b1;
                  cmd.res_status = svt_pkg::ST_OK;
                  state_in       = S_FINISH;
               end
            endcase
         end
         S_SCAN: begin
            if (stat.at_end) begin
               unique case (stat.op)
                  svt_pkg::OP_INSERT: begin
                     cmd.k_init = 1'b1;
                     state_in   = S_ISH_RD;
                  end
                  svt_pkg::OP_LOOKUP: begin
                     cmd.set_res    = 1'b1;
                     cmd.res_status = svt_pkg::ST_OK;
                     state_in       = S_FINISH;
                  end
                  default: begin
                     cmd.set_res    = 1'b1;
                     cmd.res_status = svt_pkg::ST_NOT_FOUND;
                     state_in       = S_FINISH;
                  end
               endcase
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = svt_pkg::RD_SEL_SCAN;
               state_in   = S_CMP;
            end
         end
         S_CMP: begin
            if (stat.less) begin
               cmd.idx_inc = 1'b1;
               state_in    = S_SCAN;
            end else begin
               // index now holds the first entry that is not smaller
               unique case (stat.op)
                  svt_pkg::OP_INSERT: begin
                     cmd.k_init = 1'b1;
                     state_in   = S_ISH_RD;
                  end
                  svt_pkg::OP_LOOKUP: begin
                     cmd.set_res    = 1'b1;
                     cmd.res_found  = stat.equal;
                     cmd.res_status = svt_pkg::ST_OK;
                     state_in       = S_FINISH;
                  end
                  default: begin
                     if (stat.equal) begin
                        state_in = S_DSH_RD;
                     end else begin
                        cmd.set_res    = 1'b1;
                        cmd.res_status = svt_pkg::ST_NOT_FOUND;
                        state_in       = S_FINISH;
                     end
                  end
               endcase
            end
         end
         S_ISH_RD: begin
            if (stat.ins_done) begin
               cmd.wr_en      = 1'b1;
               cmd.wr_sel     = svt_pkg::WR_SEL_VALUE;
               cmd.occ_inc    = 1'b1;
               cmd.set_res    = 1'b1;
               cmd.res_status = svt_pkg::ST_OK;
               state_in       = S_FINISH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = svt_pkg::RD_SEL_ISHIFT;
               state_in   = S_ISH_WR;
            end
         end
         S_ISH_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = svt_pkg::WR_SEL_ISHIFT;
            cmd.k_dec  = 1'b1;
            state_in   = S_ISH_RD;
         end
         S_DSH_RD: begin
            if (stat.del_done) begin
               cmd.occ_dec    = 1'b1;
               cmd.set_res    = 1'b1;
               cmd.res_found  = 1'b1;
               cmd.res_status = svt_pkg::ST_OK;
               state_in       = S_FINISH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = svt_pkg::RD_SEL_DSHIFT;
               state_in   = S_DSH_WR;
            end
         end
         S_DSH_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = svt_pkg::WR_SEL_DSHIFT;
            cmd.idx_inc = 1'b1;
            state_in    = S_DSH_RD;
         end
         S_FINISH: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> src/sorted_value_table.sv
`timescale 1ns / 1ps
// Sorted value table: holds up to CAPACITY signed 32-bit values in ascending
// order, duplicates allowed. A request carries op (insert, lookup, delete) and
// value on req_chan; each request gives exactly one response on rsp_chan with
// found, status (ok, not found, full) and the entry count after the operation.
// Insert goes before the first entry not smaller; delete removes the first
// equal entry; insert into a full table changes nothing and reports full.
// One request is worked on at a time. Every scan step and every shift step is
// one read of the entry RAM followed by a compare or a write. The worst case is
// an insert or delete on an almost full table. An unused op code or an insert
// into a full table goes from dispatch straight to the response. At the
// earliest, the next request is taken in the same cycle as the response turns
// valid. The response sits in a register; a new request is taken as soon as
// the controller is idle, even while the last response still waits. When the
// receiver stalls, the next response holds in the controller until the last
// response is taken.
// Reset empties the table (occupancy zero) and drops any pending response;
// the entry RAM needs no clearing since only entries below occupancy are read.
// Depends on svt_pkg, svt_if, svt_ram, svt_dpath and svt_ctrl.

module sorted_value_table #(
   parameter int unsigned CAPACITY = svt_pkg::DEF_CAPACITY
) (
   input logic        clock,
   input logic        reset,
   svt_req_if.sink    req_chan,
   svt_rsp_if.source  rsp_chan
);

   svt_pkg::cmd_type  cmd;
   svt_pkg::stat_type stat;

   svt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   svt_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_op          (req_chan.op),
      .req_value       (req_chan.value),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_found       (rsp_chan.found),
      .rsp_status      (rsp_chan.status),
      .rsp_entry_count (rsp_chan.entry_count)
   );

endmodule

>>> src/svt_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the sorted value table, bound to the top level.
// Depends on svt_pkg and sorted_value_table.

module svt_checker #(
   parameter int unsigned CAPACITY = svt_pkg::DEF_CAPACITY
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_found,
   input logic [svt_pkg::STATUS_W-1:0] rsp_status,
   input logic [svt_pkg::COUNT_W-1:0]  rsp_entry_count
);

   // one request at a time: busy straight after acceptance
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while previous one in progress");

   // found only with an ok status
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_status == svt_pkg::ST_OK))
      else $error("found reported with non-ok status");

   // a full status reports the capacity as entry count (checked only for CAPACITY below 128)
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == svt_pkg::ST_FULL && CAPACITY < 128)
         |-> (32'(rsp_entry_count) == CAPACITY))
      else $error("full status with count below capacity");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_found) && $stable(rsp_status)
          && $stable(rsp_entry_count)))
      else $error("stalled response changed");

endmodule

bind sorted_value_table svt_checker #(
   .CAPACITY (CAPACITY)
) u_svt_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_found       (rsp_chan.found),
   .rsp_status      (rsp_chan.status),
   .rsp_entry_count (rsp_chan.entry_count)
);
